>>> design/ehps_pkg.sv
package ehps_pkg;

  localparam int NUM_STAGES_DEF     = 4;
  localparam int ROWS_PER_STAGE_DEF = 1024;

  // Seed registers exist for up to four stages, so the stage index is two bits.
  localparam int STAGE_W = 2;
  localparam int NUM_SEEDS = 4;

  localparam int KEY_W    = 32;
  localparam int VOTE_W   = 32;
  localparam int LAMBDA_W = 8;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int PROD_W   = VOTE_W + LAMBDA_W;

  localparam int IN_TDATA_W  = KEY_W;
  localparam int OUT_TDATA_W = KEY_W + VOTE_W;

  localparam logic [31:0] HASH_MUL1 = 32'h85EB_CA6B;
  localparam logic [31:0] HASH_MUL2 = 32'hC2B2_AE35;

  localparam logic [CFG_IDX_W-1:0] REG_LAMBDA = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SEED0  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SEED1  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SEED2  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SEED3  = 3'd4;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

  localparam logic [LAMBDA_W-1:0] LAMBDA_RST = 8'd8;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [VOTE_W-1:0] total;
    logic [VOTE_W-1:0] positive;
  } slot_t;

  localparam int SLOT_W = $bits(slot_t);

  typedef struct packed {
    logic             start;
    logic [KEY_W-1:0] key;
    logic [31:0]      seed;
  } hash_req_t;

  function automatic logic [VOTE_W-1:0] sat_inc(input logic [VOTE_W-1:0] v);
    return (v == '1) ? v : v + VOTE_W'(1);
  endfunction

endpackage

>>> design/ehps_ram.sv
module ehps_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> design/ehps_hash.sv
module ehps_hash
  import ehps_pkg::*;
#(
  parameter int ROWS_PER_STAGE = ROWS_PER_STAGE_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  hash_req_t                         req,
  output logic                              done,
  output logic [$clog2(ROWS_PER_STAGE)-1:0] row
);

  localparam int ROW_W = $clog2(ROWS_PER_STAGE);
  localparam logic [31:0] ROWS32 = 32'(ROWS_PER_STAGE);
  // floor(2^32 / rows): the quotient estimate is at most one short.
  localparam longint unsigned RECIP_L = (64'd1 << 32) / ROWS_PER_STAGE;
  localparam logic [31:0] RECIP = 32'(RECIP_L);

  logic [5:0]  vld;
  logic [31:0] seed_q;
  logic [31:0] mix1;
  logic [31:0] mix2;
  logic [31:0] hfin;
  logic [31:0] quo;
  logic [31:0] qmul;

  logic [31:0] x0;
  logic [31:0] x1;
  logic [31:0] x2;
  logic [31:0] m1;
  logic [31:0] m2;
  logic [63:0] qprod;
  logic [31:0] rem;
  logic [31:0] rem_fix;

  always_comb begin
    x0      = req.key ^ req.seed;
    x0      = x0 ^ (x0 >> 16);
    m1      = x0 * HASH_MUL1;
    x1      = mix1 ^ (mix1 >> 13);
    m2      = x1 * HASH_MUL2;
    x2      = mix2 ^ (mix2 >> 16);
    qprod   = 64'(hfin) * 64'(RECIP);
    rem     = hfin - qmul;
    rem_fix = (rem >= ROWS32) ? rem - ROWS32 : rem;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[4:0], req.start};
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      mix1   <= m1;
      seed_q <= req.seed;
    end
    if (vld[0]) begin
      mix2 <= m2;
    end
    if (vld[1]) begin
      hfin <= x2 + seed_q;
    end
    if (vld[2]) begin
      quo <= qprod[63:32];
    end
    if (vld[3]) begin
      qmul <= quo * ROWS32;
    end
    if (vld[4]) begin
      row <= rem_fix[ROW_W-1:0];
    end
  end

  assign done = vld[5];

endmodule

>>> design/elastic_heavy_part_sketch_core.sv
// Multi-stage heavy-hitter table. Each input word is an insert (tuser 0) or a
// query (tuser 1) of a 32-bit key; every word yields exactly one result word.
// All slots of all stages live in one single-port-read memory of
// NUM_STAGES * ROWS_PER_STAGE entries, and the block works on one word at a
// time, walking the stages in order. Each visited stage takes a launch, a
// six-step hash and row reduction, one memory read, and an update that, for
// an insert, writes the slot back. An insert that settles in the first stage
// visits only that stage; a query or a spilling insert visits all NUM_STAGES
// stages, and any result may wait on m_axis_tready. After reset the block
// clears the memory, one entry per cycle, before s_axis_tready first rises;
// configuration writes are taken during that time as always.
module elastic_heavy_part_sketch_core
  import ehps_pkg::*;
#(
  parameter int NUM_STAGES     = NUM_STAGES_DEF,
  parameter int ROWS_PER_STAGE = ROWS_PER_STAGE_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // key
  input  logic                   s_axis_tuser,  // operation
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // spilled_key, count
  output logic                   m_axis_tuser,  // spilled
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int DEPTH  = NUM_STAGES * ROWS_PER_STAGE;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int ROW_W  = $clog2(ROWS_PER_STAGE);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);
  localparam logic [ADDR_W-1:0] STAGE_STRIDE = ADDR_W'(ROWS_PER_STAGE);
  localparam logic [STAGE_W-1:0] LAST_STAGE = STAGE_W'(NUM_STAGES - 1);

  typedef enum logic [6:0] {
    ST_CLEAR  = 7'b0000001,
    ST_IDLE   = 7'b0000010,
    ST_LAUNCH = 7'b0000100,
    ST_HASH   = 7'b0001000,
    ST_READ   = 7'b0010000,
    ST_UPDATE = 7'b0100000,
    ST_FINISH = 7'b1000000
  } state_t;

  state_t state;

  logic [LAMBDA_W-1:0] lambda;
  logic [31:0]         seed [NUM_SEEDS];

  logic [ADDR_W-1:0]   clr_addr;
  logic [STAGE_W-1:0]  stage;
  logic [ADDR_W-1:0]   base;
  logic [ADDR_W-1:0]   slot_addr;
  logic                op;
  logic [KEY_W-1:0]    cur;
  logic [VOTE_W-1:0]   sum;
  logic                spill;
  slot_t               rd_q;
  logic [PROD_W-1:0]   prod;

  hash_req_t           hreq;
  logic                hdone;
  logic [ROW_W-1:0]    hrow;

  logic                ram_wr_en;
  logic [ADDR_W-1:0]   ram_wr_addr;
  slot_t               ram_wr_data;
  logic                ram_rd_en;
  logic [ADDR_W-1:0]   ram_rd_addr;
  slot_t               ram_rd_data;

  logic [VOTE_W-1:0]   all1;
  logic                empty;
  logic                match;
  logic                swap;
  logic                last;
  slot_t               new_slot;
  logic [VOTE_W:0]     sum_add;
  logic [VOTE_W-1:0]   sum_next;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      lambda <= LAMBDA_RST;
      seed[0] <= 32'd1;
      seed[1] <= 32'd2;
      seed[2] <= 32'd3;
      seed[3] <= 32'd4;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_LAMBDA: lambda  <= cfg_data[LAMBDA_W-1:0];
        REG_SEED0:  seed[0] <= cfg_data;
        REG_SEED1:  seed[1] <= cfg_data;
        REG_SEED2:  seed[2] <= cfg_data;
        REG_SEED3:  seed[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  assign hreq.start = (state == ST_LAUNCH);
  assign hreq.key   = cur;
  assign hreq.seed  = seed[stage];

  ehps_hash #(
    .ROWS_PER_STAGE(ROWS_PER_STAGE)
  ) u_hash (
    .clk (clk),
    .rst (rst),
    .req (hreq),
    .done(hdone),
    .row (hrow)
  );

  assign ram_rd_en   = (state == ST_HASH) && hdone;
  assign ram_rd_addr = base + ADDR_W'(hrow);

  always_comb begin
    all1     = sat_inc(rd_q.total);
    empty    = (rd_q.total == '0);
    match    = (rd_q.key == cur);
    swap     = (PROD_W'(all1) >= prod);
    last     = (stage == LAST_STAGE);
    sum_add  = {1'b0, sum} + {1'b0, rd_q.positive};
    sum_next = sum_add[VOTE_W] ? '1 : sum_add[VOTE_W-1:0];

    // An empty slot is judged on its total, before the key compare.
    if (empty) begin
      new_slot = '{key: cur, total: VOTE_W'(1), positive: VOTE_W'(1)};
    end else if (match) begin
      new_slot = '{key: rd_q.key, total: all1, positive: sat_inc(rd_q.positive)};
    end else if (swap) begin
      new_slot = '{key: cur, total: sat_inc(all1), positive: sat_inc(rd_q.positive)};
    end else begin
      new_slot = '{key: rd_q.key, total: all1, positive: rd_q.positive};
    end

    if (state == ST_CLEAR) begin
      ram_wr_en   = 1'b1;
      ram_wr_addr = clr_addr;
      ram_wr_data = '0;
    end else begin
      ram_wr_en   = (state == ST_UPDATE) && (op == OP_INSERT);
      ram_wr_addr = slot_addr;
      ram_wr_data = new_slot;
    end
  end

  ehps_ram #(
    .WIDTH(SLOT_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk    (clk),
    .wr_en  (ram_wr_en),
    .wr_addr(ram_wr_addr),
    .wr_data(ram_wr_data),
    .rd_en  (ram_rd_en),
    .rd_addr(ram_rd_addr),
    .rd_data(ram_rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_CLEAR;
      clr_addr      <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (state == ST_FINISH && (!m_axis_tvalid || m_axis_tready)) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + ADDR_W'(1);
          if (clr_addr == LAST_ADDR) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            state <= ST_LAUNCH;
          end
        end
        ST_LAUNCH: begin
          state <= ST_HASH;
        end
        ST_HASH: begin
          if (hdone) begin
            state <= ST_READ;
          end
        end
        ST_READ: begin
          state <= ST_UPDATE;
        end
        ST_UPDATE: begin
          if (op == OP_INSERT && (empty || match)) begin
            state <= ST_FINISH;
          end else if (last) begin
            state <= ST_FINISH;
          end else begin
            state <= ST_LAUNCH;
          end
        end
        ST_FINISH: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_CLEAR;
      endcase
    end
  end

  // Item datapath; no reset needed, every field is loaded before use.
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        op    <= s_axis_tuser;
        cur   <= s_axis_tdata;
        stage <= '0;
        base  <= '0;
        sum   <= '0;
        spill <= 1'b0;
      end
      ST_HASH: begin
        slot_addr <= ram_rd_addr;
      end
      ST_READ: begin
        rd_q <= ram_rd_data;
        prod <= PROD_W'(ram_rd_data.positive) * PROD_W'(lambda);
      end
      ST_UPDATE: begin
        stage <= stage + STAGE_W'(1);
        base  <= base + STAGE_STRIDE;
        if (op == OP_QUERY) begin
          if (match) begin
            sum <= sum_next;
          end
        end else if (!empty && !match) begin
          if (swap) begin
            cur <= rd_q.key;
          end
          if (last) begin
            spill <= 1'b1;
          end
        end
      end
      ST_FINISH: begin
        if (!m_axis_tvalid || m_axis_tready) begin
          if (op == OP_QUERY) begin
            m_axis_tuser <= 1'b0;
            m_axis_tdata <= {sum, {KEY_W{1'b0}}};
          end else if (spill) begin
            m_axis_tuser <= 1'b1;
            m_axis_tdata <= {VOTE_W'(1), cur};
          end else begin
            m_axis_tuser <= 1'b0;
            m_axis_tdata <= '0;
          end
        end
      end
      default: ;
    endcase
  end

endmodule

>>> design/ehps_checker.sv
module ehps_checker
  import ehps_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   s_axis_tvalid,
  input logic                   s_axis_tready,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input logic                   m_axis_tuser
);

  // The memory is being cleared right after reset, so no word is taken.
  a_clear_after_reset: assert property (@(posedge clk)
    $past(rst) && !rst |-> !s_axis_tready)
    else $error("input ready right after reset");

  // One word at a time: the block is busy in the cycle after it takes a word.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input ready in the cycle after an accepted word");

  a_spill_count_one: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[63:32] == 32'd1)
    else $error("spilled result without a count of one");

  a_no_spill_key_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[31:0] == 32'd0)
    else $error("spilled key nonzero without a spill");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result word changed");

endmodule

bind elastic_heavy_part_sketch_core ehps_checker u_checker (.*);

>>> verif/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import ehps_pkg::*;

  localparam int STAGES       = NUM_STAGES_DEF;
  localparam int ROWS         = ROWS_PER_STAGE_DEF;
  localparam int ROW_W        = $clog2(ROWS_PER_STAGE_DEF);
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 40;
  localparam int IDLE_PCT     = 28;

  // Indexes past the last register; writes to them must change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  typedef struct packed {
    logic              spilled;
    logic [KEY_W-1:0]  spilled_key;
    logic [VOTE_W-1:0] count;
  } result_t;

  typedef struct packed {
    logic             op;
    logic [KEY_W-1:0] key;
    logic             typed;
    result_t          want;
  } dir_row_t;

  // Up to four distinct keys no insert can spill, and with lambda at eight no
  // key is displaced yet, so the early results follow directly.
  localparam int DIR_N = 14;
  localparam dir_row_t DIR_ROWS [DIR_N] = '{
    '{OP_QUERY,  32'h0000_0000, 1'b1, '{1'b0, 32'h0, 32'd0}},
    '{OP_QUERY,  32'hFFFF_FFFF, 1'b1, '{1'b0, 32'h0, 32'd0}},
    '{OP_INSERT, 32'h0000_0000, 1'b1, '{1'b0, 32'h0, 32'd0}},
    '{OP_INSERT, 32'hFFFF_FFFF, 1'b1, '{1'b0, 32'h0, 32'd0}},
    '{OP_INSERT, 32'h0000_0000, 1'b1, '{1'b0, 32'h0, 32'd0}},
    '{OP_QUERY,  32'h0000_0000, 1'b1, '{1'b0, 32'h0, 32'd2}},
    '{OP_QUERY,  32'hFFFF_FFFF, 1'b1, '{1'b0, 32'h0, 32'd1}},
    '{OP_INSERT, 32'h8000_0001, 1'b1, '{1'b0, 32'h0, 32'd0}},
    '{OP_INSERT, 32'h7FFF_FFFE, 1'b1, '{1'b0, 32'h0, 32'd0}},
    '{OP_QUERY,  32'h8000_0001, 1'b1, '{1'b0, 32'h0, 32'd1}},
    '{OP_INSERT, 32'h1234_5678, 1'b0, '0},
    '{OP_QUERY,  32'h1234_5678, 1'b0, '0},
    '{OP_INSERT, 32'hA5A5_A5A5, 1'b0, '0},
    '{OP_QUERY,  32'h5A5A_5A5A, 1'b0, '0}
  };

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;   // key
  logic                   s_axis_tuser;   // operation
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;   // spilled_key, count
  logic                   m_axis_tuser;   // spilled
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  // Shadow of the slot table and the registers.
  logic [KEY_W-1:0]    slot_key   [STAGES][ROWS];
  logic [VOTE_W-1:0]   slot_total [STAGES][ROWS];
  logic [VOTE_W-1:0]   slot_pos   [STAGES][ROWS];
  logic [LAMBDA_W-1:0] lambda_r;
  logic [31:0]         seed_r [NUM_SEEDS];

  result_t          due_results [$];
  logic [KEY_W-1:0] hot_keys [$];
  int               errors = 0;
  int               idle_pct = IDLE_PCT;
  int               phase = 0;
  logic             hold_done = 1'b0;

  elastic_heavy_part_sketch_core dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #6 clk = ~clk;

  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic logic [VOTE_W-1:0] vote_up(input logic [VOTE_W-1:0] v);
    return (v == {VOTE_W{1'b1}}) ? v : v + VOTE_W'(1);
  endfunction

  function automatic logic [ROW_W-1:0] row_of(input logic [KEY_W-1:0] k, input int stg);
    logic [31:0] s;
    logic [31:0] h;
    s = seed_r[stg];
    h = k ^ s;
    h = h ^ (h >> 16);
    h = h * HASH_MUL1;
    h = h ^ (h >> 13);
    h = h * HASH_MUL2;
    h = h ^ (h >> 16);
    h = h + s;
    h = h % 32'(ROWS);
    return h[ROW_W-1:0];
  endfunction

  // Applies one word to the shadow table and returns the result it yields.
  function automatic result_t heavy_part_step(input logic op, input logic [KEY_W-1:0] k);
    result_t          res;
    logic [KEY_W-1:0] carried;
    logic [KEY_W-1:0] displaced;
    logic [63:0]      sum;
    logic [ROW_W-1:0] r;
    res = '0;
    if (op == OP_QUERY) begin
      sum = '0;
      for (int s = 0; s < STAGES; s++) begin
        r = row_of(k, s);
        if (slot_key[s][r] == k) sum = sum + 64'(slot_pos[s][r]);
      end
      res.count = (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
      return res;
    end
    carried = k;
    for (int s = 0; s < STAGES; s++) begin
      r = row_of(carried, s);
      if (slot_total[s][r] == '0) begin
        slot_key[s][r]   = carried;
        slot_total[s][r] = 32'd1;
        slot_pos[s][r]   = 32'd1;
        return res;
      end
      if (slot_key[s][r] == carried) begin
        slot_total[s][r] = vote_up(slot_total[s][r]);
        slot_pos[s][r]   = vote_up(slot_pos[s][r]);
        return res;
      end
      slot_total[s][r] = vote_up(slot_total[s][r]);
      if (64'(slot_total[s][r]) >= 64'(slot_pos[s][r]) * 64'(lambda_r)) begin
        displaced        = slot_key[s][r];
        slot_key[s][r]   = carried;
        carried          = displaced;
        slot_pos[s][r]   = vote_up(slot_pos[s][r]);
        slot_total[s][r] = vote_up(slot_total[s][r]);
      end
    end
    res.spilled     = 1'b1;
    res.spilled_key = carried;
    res.count       = 32'd1;
    return res;
  endfunction

  // Called right after a rising edge; returns at the edge that takes the word.
  task automatic send_word(input logic op, input logic [KEY_W-1:0] k,
                           input logic typed, input result_t want);
    result_t res;
    @(negedge clk);
    while ($urandom_range(0, 99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= k;
    s_axis_tuser  <= op;
    do @(posedge clk); while (!s_axis_tready);
    res = heavy_part_step(op, k);
    due_results.insert(due_results.size(), typed ? want : res);
  endtask

  task automatic drain;
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_LAMBDA: lambda_r  = val[LAMBDA_W-1:0];
      REG_SEED0:  seed_r[0] = val;
      REG_SEED1:  seed_r[1] = val;
      REG_SEED2:  seed_r[2] = val;
      REG_SEED3:  seed_r[3] = val;
      default: ;
    endcase
  endtask

  task automatic set_all_seeds(input logic [31:0] s0, input logic [31:0] s1,
                               input logic [31:0] s2, input logic [31:0] s3);
    set_reg(REG_SEED0, s0);
    set_reg(REG_SEED1, s1);
    set_reg(REG_SEED2, s2);
    set_reg(REG_SEED3, s3);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Keys sharing one stage-zero row; with equal seeds they share it in every
  // stage, which drives the swap and spill paths hard.
  task automatic gather_hot_keys(input int n);
    logic [ROW_W-1:0] target;
    logic [KEY_W-1:0] k;
    target = row_of($urandom, 0);
    hot_keys.delete();
    while (hot_keys.size() < n) begin
      k = $urandom;
      if (row_of(k, 0) == target) hot_keys.insert(hot_keys.size(), k);
    end
  endtask

  task automatic stream_words(input int n);
    int roll;
    logic [KEY_W-1:0] hot;
    for (int i = 0; i < n; i++) begin
      roll = $urandom_range(0, 99);
      hot  = hot_keys[$urandom_range(0, hot_keys.size() - 1)];
      if (roll < 55)      send_word(OP_INSERT, hot, 1'b0, '0);
      else if (roll < 78) send_word(OP_QUERY, hot, 1'b0, '0);
      else if (roll < 90) send_word(OP_INSERT, $urandom, 1'b0, '0);
      else                send_word(OP_QUERY, $urandom, 1'b0, '0);
    end
    drain();
  endtask

  initial begin
    logic [31:0] shared_seed;
    for (int s = 0; s < STAGES; s++) begin
      for (int r = 0; r < ROWS; r++) begin
        slot_key[s][r]   = '0;
        slot_total[s][r] = '0;
        slot_pos[s][r]   = '0;
      end
    end
    lambda_r  = LAMBDA_RST;
    seed_r[0] = 32'd1;
    seed_r[1] = 32'd2;
    seed_r[2] = 32'd3;
    seed_r[3] = 32'd4;
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = OP_INSERT;
    cfg_valid     = 1'b0;
    cfg_index     = REG_LAMBDA;
    cfg_data      = '0;
    repeat (3) @(negedge clk);
    rst <= 1'b0;

    phase = 1;
    for (int i = 0; i < DIR_N; i++)
      send_word(DIR_ROWS[i].op, DIR_ROWS[i].key, DIR_ROWS[i].typed, DIR_ROWS[i].want);
    drain();

    // Lambda one swaps on every mismatch; zero seeds, spare indexes ignored.
    set_reg(REG_LAMBDA, 32'd1);
    set_reg(REG_SPARE_LO, $urandom);
    set_reg(REG_SPARE_HI, $urandom);
    set_all_seeds(32'h0, 32'h0, 32'h0, 32'h0);
    gather_hot_keys(6);
    phase = 2;
    stream_words(280);

    // Lambda zero: the swap condition always holds.
    set_reg(REG_LAMBDA, 32'd0);
    set_all_seeds(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    gather_hot_keys(8);
    phase = 3;
    stream_words(250);

    // Largest lambda, hardly any swaps, and no idling on either side.
    shared_seed = $urandom;
    set_reg(REG_LAMBDA, 32'd255);
    set_all_seeds(shared_seed, shared_seed, shared_seed, shared_seed);
    gather_hot_keys(6);
    idle_pct = 0;
    phase = 4;
    stream_words(250);

    idle_pct = IDLE_PCT;
    set_reg(REG_LAMBDA, $urandom_range(2, 16));
    set_all_seeds($urandom, $urandom, $urandom, $urandom);
    gather_hot_keys(10);
    phase = 5;
    stream_words(260);

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Result side; holds off once for a long stretch so the input backs up.
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (phase == 2 && !hold_done) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_done = 1'b1;
      end
      m_axis_tready <= ($urandom_range(0, 99) >= idle_pct);
    end
  end

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = '{m_axis_tuser, m_axis_tdata[KEY_W-1:0], m_axis_tdata[KEY_W +: VOTE_W]};
      if (due_results.size() == 0) begin
        errors++;
        $display("%0t: result word with none expected: spilled %0d key %h count %0d",
                 $time, got.spilled, got.spilled_key, got.count);
      end else begin
        want = due_results.pop_front();
        if (got.spilled != want.spilled) begin
          errors++;
          $display("%0t: spilled expected %0d actual %0d",
                   $time, want.spilled, got.spilled);
        end
        if (got.spilled_key != want.spilled_key) begin
          errors++;
          $display("%0t: spilled_key expected %h actual %h",
                   $time, want.spilled_key, got.spilled_key);
        end
        if (got.count != want.count) begin
          errors++;
          $display("%0t: count expected %0d actual %0d", $time, want.count, got.count);
        end
      end
    end
  end

endmodule
